// ----- hdl/sha1md_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-1 message digest package
// Shared constants, codes and the command and status types that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package sha1md_pkg;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PadMark = 8'h80;

    localparam int NumRounds = 80;
    localparam int CntW      = $clog2(NumRounds);
    localparam logic [CntW-1:0] LastRound = CntW'(NumRounds - 1);

    localparam int NumWords = 5;
    localparam int IdxW     = 3;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(NumWords - 1);

    localparam logic [1:0] KindByte   = 2'd0;
    localparam logic [1:0] KindFinal  = 2'd1;
    localparam logic [1:0] KindEnd    = 2'd2;
    localparam logic [1:0] KindUnused = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_LEN,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_DATA,
        PH_WRAP,
        PH_LAST
    } t_phase;

    typedef enum logic [1:0] {
        STG_CH,
        STG_PAR1,
        STG_MAJ,
        STG_PAR2
    } t_stage;

    typedef struct packed {
        logic            put_byte;
        logic            load;
        logic            round;
        logic            add;
        logic            pad;
        logic            clear_all;
        logic            put_len;
        logic            restart;
        t_stage          stage;
        logic [IdxW-1:0] out_idx;
    } t_cmd;

    typedef struct packed {
        logic pos_last;
        logic pad_wrap;
    } t_sts;

endpackage

// ----- hdl/sha1_message_digest.sv -----
// ----------------------------------------------------------------------------
// SHA-1 message digest
// Hashes a byte stream and returns the five digest words at message end.
// ----------------------------------------------------------------------------
// A message byte is taken while idle; the byte that fills a 64-byte block starts
// a compression (load, 80 rounds of the one-round-per-cycle compression unit, add).
// Message end takes the pad and length steps plus one or two compressions, then
// presents the five digest words at one per cycle while the receiver is ready.
// A synchronous active-low reset loads the initial chaining values, clears
// the bit count and returns the controller to idle.
// ----------------------------------------------------------------------------
module sha1_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast
);

    sha1md_pkg::t_cmd w_cmd;
    sha1md_pkg::t_sts w_sts;

    sha1md_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_kind      (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    sha1md_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (s_axis_tdata),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_word  (m_axis_tdata)
    );

    assign m_axis_tuser = w_cmd.out_idx;
    assign m_axis_tlast = (w_cmd.out_idx == sha1md_pkg::LastIdx);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("digest output overlaps input acceptance");

    a_back_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("block not ready after last digest word");

    a_first_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> (m_axis_tuser == '0))
        else $error("digest does not start at word zero");

    a_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1))
        else $error("digest word index did not advance");

endmodule

// ----- hdl/sha1md_ctrl.sv -----
// ----------------------------------------------------------------------------
// SHA-1 controller
// Sequences byte intake, block compression, final padding and digest output.
// ----------------------------------------------------------------------------
module sha1md_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic [1:0]             i_kind,
    input  logic                   i_out_ready,
    input  sha1md_pkg::t_sts       i_sts,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    output sha1md_pkg::t_cmd       o_cmd
);

    sha1md_pkg::t_state             r_state, n_state;
    sha1md_pkg::t_phase             r_phase, n_phase;
    logic                           r_final, n_final;
    logic [sha1md_pkg::CntW-1:0]    r_cnt, n_cnt;
    logic [sha1md_pkg::IdxW-1:0]    r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha1md_pkg::ST_IDLE;
            r_phase <= sha1md_pkg::PH_DATA;
            r_final <= 1'b0;
            r_cnt   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_final <= n_final;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_final = r_final;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        case (r_state)
            sha1md_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_kind)
                        sha1md_pkg::KindByte: begin
                            if (i_sts.pos_last) begin
                                n_state = sha1md_pkg::ST_LOAD;
                                n_phase = sha1md_pkg::PH_DATA;
                                n_final = 1'b0;
                            end
                        end
                        sha1md_pkg::KindFinal: begin
                            if (i_sts.pos_last) begin
                                n_state = sha1md_pkg::ST_LOAD;
                                n_phase = sha1md_pkg::PH_DATA;
                                n_final = 1'b1;
                            end else begin
                                n_state = sha1md_pkg::ST_PAD;
                            end
                        end
                        sha1md_pkg::KindEnd: begin
                            n_state = sha1md_pkg::ST_PAD;
                        end
                        default: begin
                            n_state = sha1md_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            sha1md_pkg::ST_LOAD: begin
                n_state = sha1md_pkg::ST_ROUND;
                n_cnt   = '0;
            end
            sha1md_pkg::ST_ROUND: begin
                if (r_cnt == sha1md_pkg::LastRound) begin
                    n_state = sha1md_pkg::ST_ADD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            sha1md_pkg::ST_ADD: begin
                case (r_phase)
                    sha1md_pkg::PH_DATA: begin
                        n_state = r_final ? sha1md_pkg::ST_PAD : sha1md_pkg::ST_IDLE;
                        n_final = 1'b0;
                    end
                    sha1md_pkg::PH_WRAP: begin
                        n_state = sha1md_pkg::ST_LEN;
                    end
                    default: begin
                        n_state = sha1md_pkg::ST_OUT;
                        n_idx   = '0;
                    end
                endcase
            end
            sha1md_pkg::ST_PAD: begin
                if (i_sts.pad_wrap) begin
                    n_state = sha1md_pkg::ST_LOAD;
                    n_phase = sha1md_pkg::PH_WRAP;
                end else begin
                    n_state = sha1md_pkg::ST_LEN;
                    n_phase = sha1md_pkg::PH_DATA;
                end
            end
            sha1md_pkg::ST_LEN: begin
                n_state = sha1md_pkg::ST_LOAD;
                n_phase = sha1md_pkg::PH_LAST;
            end
            sha1md_pkg::ST_OUT: begin
                if (i_out_ready) begin
                    if (r_idx == sha1md_pkg::LastIdx) begin
                        n_state = sha1md_pkg::ST_IDLE;
                        n_phase = sha1md_pkg::PH_DATA;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = sha1md_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        o_cmd         = '0;
        o_cmd.out_idx = r_idx;
        if (r_cnt < sha1md_pkg::CntW'(20)) begin
            o_cmd.stage = sha1md_pkg::STG_CH;
        end else if (r_cnt < sha1md_pkg::CntW'(40)) begin
            o_cmd.stage = sha1md_pkg::STG_PAR1;
        end else if (r_cnt < sha1md_pkg::CntW'(60)) begin
            o_cmd.stage = sha1md_pkg::STG_MAJ;
        end else begin
            o_cmd.stage = sha1md_pkg::STG_PAR2;
        end
        case (r_state)
            sha1md_pkg::ST_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.put_byte = i_in_valid &&
                                 (i_kind == sha1md_pkg::KindByte ||
                                  i_kind == sha1md_pkg::KindFinal);
            end
            sha1md_pkg::ST_LOAD: begin
                o_cmd.load = 1'b1;
            end
            sha1md_pkg::ST_ROUND: begin
                o_cmd.round = 1'b1;
            end
            sha1md_pkg::ST_ADD: begin
                o_cmd.add = 1'b1;
            end
            sha1md_pkg::ST_PAD: begin
                o_cmd.pad = 1'b1;
            end
            sha1md_pkg::ST_LEN: begin
                o_cmd.put_len   = 1'b1;
                o_cmd.clear_all = (r_phase == sha1md_pkg::PH_WRAP);
            end
            sha1md_pkg::ST_OUT: begin
                o_out_valid   = 1'b1;
                o_cmd.restart = i_out_ready && (r_idx == sha1md_pkg::LastIdx);
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- hdl/sha1md_dp.sv -----
// ----------------------------------------------------------------------------
// SHA-1 datapath
// Block buffer doubling as the message schedule window, round registers,
// chaining words and the message bit count.
// ----------------------------------------------------------------------------
module sha1md_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [7:0]             i_byte,
    input  sha1md_pkg::t_cmd       i_cmd,
    output sha1md_pkg::t_sts       o_sts,
    output logic [31:0]            o_word
);

    logic [31:0] r_blk [16];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_h0, r_h1, r_h2, r_h3, r_h4;
    logic [63:0] r_bits;

    logic [5:0]  w_pos;
    logic [3:0]  w_wi;
    logic [1:0]  w_lane;
    logic [4:0]  w_sh;
    logic [31:0] w_byte_sh;
    logic [31:0] w_mark;
    logic [31:0] w_keep;
    logic [31:0] w_sched;
    logic [31:0] w_f;
    logic [31:0] w_k;
    logic [31:0] w_t;

    assign w_pos  = r_bits[8:3];
    assign w_wi   = w_pos[5:2];
    assign w_lane = w_pos[1:0];
    assign w_sh   = {~w_lane, 3'b000};

    assign w_byte_sh = {24'd0, i_byte} << w_sh;
    assign w_mark    = {24'd0, sha1md_pkg::PadMark} << w_sh;
    assign w_keep    = 32'hFFFFFF00 << w_sh;

    assign o_sts.pos_last = (w_pos == 6'd63);
    assign o_sts.pad_wrap = (w_pos >= 6'd56);

    assign w_sched = r_blk[13] ^ r_blk[8] ^ r_blk[2] ^ r_blk[0];

    always_comb begin
        case (i_cmd.stage)
            sha1md_pkg::STG_CH: begin
                w_f = (r_b & r_c) | (~r_b & r_d);
                w_k = sha1md_pkg::K0;
            end
            sha1md_pkg::STG_PAR1: begin
                w_f = r_b ^ r_c ^ r_d;
                w_k = sha1md_pkg::K1;
            end
            sha1md_pkg::STG_MAJ: begin
                w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
                w_k = sha1md_pkg::K2;
            end
            default: begin
                w_f = r_b ^ r_c ^ r_d;
                w_k = sha1md_pkg::K3;
            end
        endcase
    end

    assign w_t = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + r_blk[0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                r_blk[i] <= r_blk[i+1];
            end
            r_blk[15] <= {w_sched[30:0], w_sched[31]};
        end else begin
            for (int i = 0; i < 16; i++) begin
                if (i_cmd.put_byte && 4'(i) == w_wi) begin
                    r_blk[i] <= (w_lane == 2'd0) ? {i_byte, 24'd0} : (r_blk[i] | w_byte_sh);
                end
                if (i_cmd.pad) begin
                    if (4'(i) == w_wi) begin
                        r_blk[i] <= (r_blk[i] & w_keep) | w_mark;
                    end else if (4'(i) > w_wi) begin
                        r_blk[i] <= '0;
                    end
                end
                if (i_cmd.clear_all && i < 14) begin
                    r_blk[i] <= '0;
                end
            end
            if (i_cmd.put_len) begin
                r_blk[14] <= r_bits[63:32];
                r_blk[15] <= r_bits[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a <= r_h0;
            r_b <= r_h1;
            r_c <= r_h2;
            r_d <= r_h3;
            r_e <= r_h4;
        end else if (i_cmd.round) begin
            r_a <= w_t;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_h0   <= sha1md_pkg::H0;
            r_h1   <= sha1md_pkg::H1;
            r_h2   <= sha1md_pkg::H2;
            r_h3   <= sha1md_pkg::H3;
            r_h4   <= sha1md_pkg::H4;
            r_bits <= '0;
        end else begin
            if (i_cmd.add) begin
                r_h0 <= r_h0 + r_a;
                r_h1 <= r_h1 + r_b;
                r_h2 <= r_h2 + r_c;
                r_h3 <= r_h3 + r_d;
                r_h4 <= r_h4 + r_e;
            end
            if (i_cmd.put_byte) begin
                r_bits <= r_bits + 64'd8;
            end
        end
    end

    always_comb begin
        case (i_cmd.out_idx)
            3'd0:    o_word = r_h0;
            3'd1:    o_word = r_h1;
            3'd2:    o_word = r_h2;
            3'd3:    o_word = r_h3;
            default: o_word = r_h4;
        endcase
    end

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// SHA-1 message digest testbench
// Streams byte messages into the hash block with random gaps on both sides,
// predicts the five digest words of every message with a behavioral SHA-1,
// and checks each returned word, its index and its last flag in order.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 1000000;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] data;
        int         gap;
        bit         drain;
        bit         rx_calm;
    } t_hash_req;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] data_byte
    logic [1:0]  s_axis_tuser = '0;    // [1:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [31:0] digest_word
    logic [2:0]  m_axis_tuser;         // [2:0] word_index
    logic        m_axis_tlast;

    t_hash_req    req_q[$];
    t_hash_req    staged_req;
    bit           staged = 1'b0;
    t_digest_word digest_due[$];
    t_digest_word got_word;
    t_digest_word want_word;

    logic [31:0] chain_h[sha1md_pkg::NumWords] = '{sha1md_pkg::H0, sha1md_pkg::H1,
                                                   sha1md_pkg::H2, sha1md_pkg::H3,
                                                   sha1md_pkg::H4};
    logic [31:0] blk_w[16] = '{default: '0};
    logic [63:0] msg_bits = '0;

    logic req_taken = 1'b0;
    logic word_taken = 1'b0;
    bit   rx_calm = 1'b0;
    bit   tx_idle = 1'b1;
    bit   rx_idle = 1'b1;
    int   rx_stall = 0;
    int   reqs_accepted = 0;
    int   total_reqs = 0;
    int   byte_reqs = 0;
    int   mismatches = 0;
    int   cycle_count = 0;

    sha1_message_digest u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    function automatic void compress_block();
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, t, x;
        for (int r = 0; r < 16; r++) w[r] = blk_w[r];
        for (int r = 16; r < 80; r++) begin
            x = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
            w[r] = {x[30:0], x[31]};
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int r = 0; r < 80; r++) begin
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = sha1md_pkg::K0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = sha1md_pkg::K1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1md_pkg::K2;
            end else begin
                f = b ^ c ^ d;
                k = sha1md_pkg::K3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[r];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    function automatic void absorb_byte(input logic [7:0] data);
        int pos;
        int sh;
        pos = int'(msg_bits[8:3]);
        sh = (3 - pos % 4) * 8;
        if (pos % 4 == 0) begin
            blk_w[pos / 4] = {data, 24'h0};
        end else begin
            blk_w[pos / 4][sh +: 8] = data;
        end
        msg_bits += 64'd8;
        if (pos == 63) begin
            compress_block();
        end
    endfunction

    function automatic void close_message();
        int pos;
        int wi;
        int sh;
        t_digest_word dw;
        pos = int'(msg_bits[8:3]);
        wi = pos / 4;
        sh = (3 - pos % 4) * 8;
        if (pos % 4 == 0) begin
            blk_w[wi] = {sha1md_pkg::PadMark, 24'h0};
        end else begin
            blk_w[wi] = blk_w[wi] & (32'hFFFF_FFFF << (sh + 8));
            blk_w[wi][sh +: 8] = sha1md_pkg::PadMark;
        end
        for (int i = wi + 1; i < 16; i++) blk_w[i] = '0;
        if (pos >= 56) begin
            compress_block();
            for (int i = 0; i < 16; i++) blk_w[i] = '0;
        end
        blk_w[14] = msg_bits[63:32];
        blk_w[15] = msg_bits[31:0];
        compress_block();
        for (int j = 0; j < sha1md_pkg::NumWords; j++) begin
            dw.word = chain_h[j];
            dw.index = 3'(j);
            dw.last = (j == sha1md_pkg::NumWords - 1);
            digest_due.insert(digest_due.size(), dw);
        end
        chain_h = '{sha1md_pkg::H0, sha1md_pkg::H1, sha1md_pkg::H2,
                    sha1md_pkg::H3, sha1md_pkg::H4};
        msg_bits = '0;
    endfunction

    function automatic void hash_request(input logic [1:0] kind, input logic [7:0] data);
        case (kind)
            sha1md_pkg::KindByte: begin
                absorb_byte(data);
            end
            sha1md_pkg::KindFinal: begin
                absorb_byte(data);
                close_message();
            end
            sha1md_pkg::KindEnd: begin
                close_message();
            end
            default: begin
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            word_taken <= 1'b1;
            got_word.word = m_axis_tdata;
            got_word.index = m_axis_tuser;
            got_word.last = m_axis_tlast;
            if (digest_due.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h index %0d",
                                          got_word.word, got_word.index));
            end else begin
                want_word = digest_due.pop_front();
                if (got_word.word !== want_word.word) begin
                    report_mismatch($sformatf("digest word %0d is %h, want %h",
                                              want_word.index, got_word.word, want_word.word));
                end
                if (got_word.index !== want_word.index) begin
                    report_mismatch($sformatf("word index is %0d, want %0d",
                                              got_word.index, want_word.index));
                end
                if (got_word.last !== want_word.last) begin
                    report_mismatch($sformatf("last flag on word %0d is %b, want %b",
                                              want_word.index, got_word.last, want_word.last));
                end
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            req_taken <= 1'b1;
            reqs_accepted <= reqs_accepted + 1;
            hash_request(s_axis_tuser, s_axis_tdata);
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || req_taken) begin
            if (!staged && req_q.size() != 0) begin
                staged_req = req_q.pop_front();
                staged = 1'b1;
            end
            if (staged && staged_req.drain && digest_due.size() != 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (staged && staged_req.gap != 0) begin
                staged_req.gap--;
                s_axis_tvalid <= 1'b0;
            end else if (staged) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= staged_req.data;
                s_axis_tuser <= staged_req.kind;
                rx_calm = staged_req.rx_calm;
                staged = 1'b0;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        req_taken <= 1'b0;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (word_taken) begin
                rx_stall = rx_calm ? 0 : $urandom_range(0, 13);
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
        word_taken <= 1'b0;
    end

    task automatic push_req(input logic [1:0] kind, input logic [7:0] data, input bit drain);
        t_hash_req req;
        req.kind = kind;
        req.data = data;
        req.gap = tx_idle ? $urandom_range(0, 13) : 0;
        req.drain = drain;
        req.rx_calm = !rx_idle;
        req_q.insert(req_q.size(), req);
        if (kind != sha1md_pkg::KindUnused) begin
            byte_reqs++;
        end
    endtask

    task automatic push_message(input int len, input bit drain_first);
        bit end_marker;
        end_marker = (len == 0) || ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                push_req(sha1md_pkg::KindUnused, 8'($urandom_range(0, 255)), 1'b0);
            end
            push_req((i == len - 1 && !end_marker) ? sha1md_pkg::KindFinal
                                                   : sha1md_pkg::KindByte,
                     8'($urandom_range(0, 255)), drain_first && i == 0);
        end
        if (end_marker) begin
            push_req(sha1md_pkg::KindEnd, 8'($urandom_range(0, 255)),
                     drain_first && len == 0);
        end
    endtask

    initial begin
        int len;
        int mode;

        push_req(sha1md_pkg::KindEnd, 8'hFF, 1'b0);
        push_req(sha1md_pkg::KindUnused, 8'hA5, 1'b0);
        push_req(sha1md_pkg::KindFinal, 8'h00, 1'b0);
        push_req(sha1md_pkg::KindFinal, 8'hFF, 1'b0);
        push_req(sha1md_pkg::KindByte, 8'h61, 1'b0);
        push_req(sha1md_pkg::KindByte, 8'h62, 1'b0);
        push_req(sha1md_pkg::KindFinal, 8'h63, 1'b0);
        push_req(sha1md_pkg::KindByte, 8'h61, 1'b1);
        push_req(sha1md_pkg::KindUnused, 8'h5A, 1'b0);
        push_req(sha1md_pkg::KindByte, 8'h62, 1'b0);
        push_req(sha1md_pkg::KindByte, 8'h63, 1'b0);
        push_req(sha1md_pkg::KindEnd, 8'h00, 1'b0);
        push_req(sha1md_pkg::KindByte, 8'h80, 1'b0);
        push_req(sha1md_pkg::KindByte, 8'h7F, 1'b0);
        push_req(sha1md_pkg::KindUnused, 8'hFF, 1'b0);
        push_req(sha1md_pkg::KindFinal, 8'h01, 1'b0);
        push_req(sha1md_pkg::KindEnd, 8'h3C, 1'b1);

        while (byte_reqs < 500) begin
            mode = $urandom_range(0, 3);
            tx_idle = (mode != 0) && ($urandom_range(0, 3) != 0);
            rx_idle = (mode != 0) && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: len = $urandom_range(0, 12);
                6, 7:             len = $urandom_range(50, 70);
                8:                len = $urandom_range(110, 130);
                default:          len = $urandom_range(0, 200);
            endcase
            push_message(len, $urandom_range(0, 5) == 0);
        end
        total_reqs = req_q.size();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (reqs_accepted != total_reqs || digest_due.size() != 0);
        repeat (250) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
